FILE: design/ntc_divider_voltage_to_temperature_unit_macros.svh
// assertion helpers for the ntc divider voltage to temperature unit
// each macro expects clk and rst_n in scope
`ifndef NTC_DIVIDER_VOLTAGE_TO_TEMPERATURE_UNIT_MACROS_SVH
`define NTC_DIVIDER_VOLTAGE_TO_TEMPERATURE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NTCVT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntcvt assertion failed");
// next-cycle implication
`define NTCVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntcvt assertion failed");
`else
`define NTCVT_ASSERT_IMPL(lbl, ante, cons)
`define NTCVT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: design/ntcvt_pkg.sv
`timescale 1ns / 1ps
package ntcvt_pkg;

  // field and register widths
  localparam int V_W       = 22;
  localparam int RF_W      = 27;
  localparam int T_W       = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = RF_W;

  // resistance/temperature rom
  localparam int ROM_SIZE      = 21;
  localparam int TABLE_ENTRIES = 21;
  localparam int N_USED = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE :
                          ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int IDX_W  = $clog2(ROM_SIZE);
  localparam int ROM_W  = 29;
  localparam int DEG_W  = 9;
  localparam int STEP_W = 4;
  localparam int FRAC_W = 8;

  // datapath widths
  localparam int DEN_W  = V_W;
  localparam int NUM_W  = RF_W + V_W;
  localparam int PROD_W = ROM_W + DEN_W;
  localparam int SCL_W  = PROD_W + STEP_W;
  localparam int Q_W    = STEP_W + FRAC_W;
  localparam int DVD_W  = SCL_W + FRAC_W + 1;
  localparam int CNT_W  = $clog2(Q_W + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_USED - 1);

  // reset values of the configuration registers
  localparam logic [V_W-1:0]  SUPPLY_RST = 22'd1800000;
  localparam logic [RF_W-1:0] RFIX_RST   = 27'd9747669;

  // table resistances in milliohms
  localparam logic [ROM_W-1:0] ROM_MOHM [ROM_SIZE] = '{
    29'd335670000, 29'd176680000, 29'd96790000, 29'd55350000, 29'd32650000,
    29'd19900000,  29'd12490000,  29'd10000000, 29'd8060000,  29'd5320000,
    29'd3600000,   29'd2490000,   29'd1750000,  29'd1260000,  29'd920000,
    29'd680000,    29'd510000,    29'd390000,   29'd300000,   29'd230000,
    29'd180000
  };

  // table temperatures in degrees C
  localparam logic signed [DEG_W-1:0] ROM_DEG [ROM_SIZE] = '{
    -9'sd40, -9'sd30, -9'sd20, -9'sd10, 9'sd0,   9'sd10,  9'sd20,
    9'sd25,  9'sd30,  9'sd40,  9'sd50,  9'sd60,  9'sd70,  9'sd80,
    9'sd90,  9'sd100, 9'sd110, 9'sd120, 9'sd130, 9'sd140, 9'sd150
  };

  // temperature rise from the previous entry to this one
  localparam logic [STEP_W-1:0] ROM_STEP [ROM_SIZE] = '{
    4'd0,  4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd5,  4'd5,  4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPLY = 1'b0,
    CFG_RFIX   = 1'b1
  } cfg_idx_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MNUM  = 9'b000000010,
    S_NUM   = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_CMP   = 9'b000010000,
    S_SCALE = 9'b000100000,
    S_LOAD  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // entry temperature in 1/256 degree units
  function automatic logic signed [T_W-1:0] deg_q8(input logic [IDX_W-1:0] idx);
    return T_W'($signed({ROM_DEG[idx], {FRAC_W{1'b0}}}));
  endfunction

endpackage

FILE: design/ntcvt_if.sv
`timescale 1ns / 1ps
interface ntcvt_in_if import ntcvt_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [V_W-1:0] voltage_uv;
  logic           sample_valid;

  modport source (output valid, output voltage_uv, output sample_valid, input ready);
  modport sink   (input valid, input voltage_uv, input sample_valid, output ready);
endinterface

interface ntcvt_out_if import ntcvt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [T_W-1:0] temperature_q8;
  logic                  temp_valid;

  modport source (output valid, output temperature_q8, output temp_valid, input ready);
  modport sink   (input valid, input temperature_q8, input temp_valid, output ready);
endinterface

FILE: design/ntcvt_div.sv
`timescale 1ns / 1ps
module ntcvt_div import ntcvt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dvd_hi,
  input  logic [Q_W-1:0]    dvd_lo,
  input  logic [PROD_W-1:0] dvs,
  output div_stat_t         stat,
  output logic [Q_W-1:0]    quot
);

  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]    lo_r, lo_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [PROD_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W:0]   shifted;
  logic [PROD_W:0]   trial;

  // one restoring step: bring down the next dividend bit and try the divisor
  assign shifted = {rem_r, lo_r[Q_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = dvd_hi;
      lo_nxt  = dvd_lo;
      q_nxt   = '0;
      dvs_nxt = dvs;
      cnt_nxt = CNT_W'(Q_W);
    end else if (cnt_r != '0) begin
      if (!trial[PROD_W]) begin
        rem_nxt = trial[PROD_W-1:0];
      end else begin
        rem_nxt = shifted[PROD_W-1:0];
      end
      q_nxt    = {q_r[Q_W-2:0], ~trial[PROD_W]};
      lo_nxt   = {lo_r[Q_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

FILE: design/ntc_divider_voltage_to_temperature_unit.sv
`timescale 1ns / 1ps
// sequence: a rejected sample, or a zero resistance once the numerator is formed, goes
// straight to the result; otherwise the table is walked one entry at a time (multiply,
// then compare) until it clamps at an end entry or finds the bracketing pair, which it
// interpolates by scale, load and a 12-step restoring division
// throughput: one sample at a time; the next is taken when the previous result is queued
// reset: synchronous active-low; supply and resistor registers return to 1.8 V, 9747669 mohm
`include "ntc_divider_voltage_to_temperature_unit_macros.svh"
module ntc_divider_voltage_to_temperature_unit import ntcvt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ntcvt_in_if.sink             in_ch,
  ntcvt_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  state_t                state_r, state_nxt;
  logic [V_W-1:0]        supply_r;
  logic [RF_W-1:0]       rfix_r;
  logic [V_W-1:0]        v_r, v_nxt;
  logic [DEN_W-1:0]      den_r, den_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [PROD_W-1:0]     hi_r, hi_nxt;
  logic [PROD_W-1:0]     dist_r, dist_nxt;
  logic [PROD_W-1:0]     span_r, span_nxt;
  logic [SCL_W-1:0]      scl_r, scl_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic signed [T_W-1:0] ptemp_r, ptemp_nxt;
  logic                  ptv_r, ptv_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic signed [T_W-1:0] otemp_r, otemp_nxt;
  logic                  otv_r, otv_nxt;
  logic [ROM_W-1:0]      mul_a;
  logic [DEN_W-1:0]      mul_b;
  logic [DVD_W-1:0]      dvd;
  logic                  div_start;
  div_stat_t             div_st;
  logic [Q_W-1:0]        div_q;
  logic                  in_xfer;
  logic                  out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !ovalid_r || out_ch.ready;

  assign out_ch.valid          = ovalid_r;
  assign out_ch.temperature_q8 = otemp_r;
  assign out_ch.temp_valid     = otv_r;

  // shared multiplier, always registered
  assign prod_nxt = mul_a * mul_b;

  // interpolation dividend: step * dist * 256 plus half the span for rounding
  assign dvd = {1'b0, scl_r, {FRAC_W{1'b0}}} + DVD_W'(span_r >> 1);

  ntcvt_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .dvd_hi (dvd[DVD_W-2:Q_W]),
    .dvd_lo (dvd[Q_W-1:0]),
    .dvs    (span_r),
    .stat   (div_st),
    .quot   (div_q)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    v_nxt      = v_r;
    den_nxt    = den_r;
    num_nxt    = num_r;
    idx_nxt    = idx_r;
    hi_nxt     = hi_r;
    dist_nxt   = dist_r;
    span_nxt   = span_r;
    scl_nxt    = scl_r;
    ptemp_nxt  = ptemp_r;
    ptv_nxt    = ptv_r;
    ovalid_nxt = ovalid_r;
    otemp_nxt  = otemp_r;
    otv_nxt    = otv_r;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;

    // output transfer frees the result register
    if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (!in_ch.sample_valid || in_ch.voltage_uv == '0 ||
              in_ch.voltage_uv >= supply_r) begin
            ptemp_nxt = '0;
            ptv_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            v_nxt     = in_ch.voltage_uv;
            den_nxt   = supply_r - in_ch.voltage_uv;
            state_nxt = S_MNUM;
          end
        end
      end
      // resistance numerator rfix * v
      S_MNUM: begin
        mul_a     = ROM_W'(rfix_r);
        mul_b     = v_r;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        num_nxt = prod_r[NUM_W-1:0];
        idx_nxt = '0;
        if (prod_r == '0) begin
          ptemp_nxt = '0;
          ptv_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      // table entry scaled by the denominator
      S_MUL: begin
        mul_a     = ROM_MOHM[idx_r];
        mul_b     = den_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (PROD_W'(num_r) >= prod_r) begin
          if (idx_r == '0) begin
            ptemp_nxt = deg_q8('0);
            ptv_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            dist_nxt  = hi_r - PROD_W'(num_r);
            span_nxt  = hi_r - prod_r;
            state_nxt = S_SCALE;
          end
        end else begin
          hi_nxt = prod_r;
          if (idx_r == LAST_IDX) begin
            ptemp_nxt = deg_q8(LAST_IDX);
            ptv_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_SCALE: begin
        scl_nxt   = dist_r * ROM_STEP[idx_r];
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_st.done) begin
          ptemp_nxt = deg_q8(idx_r - 1'b1) + $signed(T_W'(div_q));
          ptv_nxt   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          otemp_nxt  = ptemp_r;
          otv_nxt    = ptv_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      supply_r <= SUPPLY_RST;
      rfix_r   <= RFIX_RST;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SUPPLY: supply_r <= cfg_wdata[V_W-1:0];
          CFG_RFIX:   rfix_r   <= cfg_wdata;
          default:    ;
        endcase
      end
    end
    v_r     <= v_nxt;
    den_r   <= den_nxt;
    num_r   <= num_nxt;
    idx_r   <= idx_nxt;
    hi_r    <= hi_nxt;
    dist_r  <= dist_nxt;
    span_r  <= span_nxt;
    scl_r   <= scl_nxt;
    prod_r  <= prod_nxt;
    ptemp_r <= ptemp_nxt;
    ptv_r   <= ptv_nxt;
    otemp_r <= otemp_nxt;
    otv_r   <= otv_nxt;
  end

  // checks
  `NTCVT_ASSERT_NEXT(a_bad_sample_done, in_xfer && !in_ch.sample_valid, state_r == S_DONE)
  `NTCVT_ASSERT_IMPL(a_dist_in_span, state_r == S_SCALE, dist_r != '0 && dist_r <= span_r)
  `NTCVT_ASSERT_IMPL(a_div_done_state, div_st.done, state_r == S_DIV)
  `NTCVT_ASSERT_IMPL(a_quot_range, div_st.done, div_q <= (Q_W'(ROM_STEP[idx_r]) << FRAC_W))
  `NTCVT_ASSERT_IMPL(a_div_start_idle, div_start, !div_st.busy)

endmodule
